/* design/piece_table_editor_core_macros.svh */
// Assertion helpers for the piece table editor checkers.
`ifndef PIECE_TABLE_EDITOR_CORE_MACROS_SVH
`define PIECE_TABLE_EDITOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pte check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pte check failed");

`endif

/* design/pte_pkg.sv */
`default_nettype none
package pte_pkg;

  localparam int DEF_MAX_PIECES = 32;
  localparam int DEF_POS_BITS   = 24;
  localparam int FUNC_BITS      = 3;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_BITS     = 6;

  localparam logic [FUNC_BITS-1:0] FN_LOAD = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_INS  = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_ERA  = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_REP  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_LOC  = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_READ = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;
    logic commit;
    logic wr_en;
  } pte_ctl_t;

endpackage
`default_nettype wire

/* design/pte_if.sv */
`default_nettype none
interface pte_in_if #(parameter int POS_BITS = pte_pkg::DEF_POS_BITS);
  logic                           valid;
  logic                           ready;
  logic [pte_pkg::FUNC_BITS-1:0]  func;
  logic [POS_BITS-1:0]            position;
  logic [POS_BITS-1:0]            length;
  logic [POS_BITS-1:0]            insert_length;
  modport source (output valid, func, position, length, insert_length, input ready);
  modport sink   (input valid, func, position, length, insert_length, output ready);
endinterface

interface pte_out_if #(parameter int POS_BITS = pte_pkg::DEF_POS_BITS);
  logic                            valid;
  logic                            ready;
  logic [pte_pkg::STATUS_BITS-1:0] status;
  logic                            span_source;
  logic [POS_BITS-1:0]             span_start;
  logic [POS_BITS-1:0]             span_length;
  logic [POS_BITS-1:0]             doc_length;
  logic [pte_pkg::COUNT_BITS-1:0]  span_count;
  logic                            last;
  modport source (output valid, status, span_source, span_start, span_length, doc_length,
                  span_count, last, input ready);
  modport sink   (input valid, status, span_source, span_start, span_length, doc_length,
                  span_count, last, output ready);
endinterface
`default_nettype wire

/* design/piece_table_editor_core.sv */
`default_nettype none
// Piece table editor core. Holds up to MAX_PIECES spans (source, start, length)
// in a ring of cells, plus document length and add-buffer fill. One word is taken
// at a time; in_ch.ready is high only while the core is idle. Load writes its span
// into rebuild entry zero as it is taken and commits it in S_LOADC. Every other
// operation that passes its checks in S_CHK (and S_OVF for edits), save a zero-length
// read, rotates the whole ring once, visiting each used span in four phases and
// shifting past each empty slot; edits then pass S_TAIL, S_MRG, S_FLUSH and S_COMMIT
// to flush the normalizer and commit. Edits rebuild the normalized table into the
// cells' rebuild entries as the ring turns and commit it at once only if it
// fits; otherwise table_full is returned and the table is untouched. A read range
// returns one word per overlapping span, last flagged on the final one; every
// other operation returns one word with last set. A stalled out_ch holds the
// ring, so throughput follows the sink.
module piece_table_editor_core #(
  parameter int MAX_PIECES = pte_pkg::DEF_MAX_PIECES,
  parameter int POS_BITS   = pte_pkg::DEF_POS_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  pte_in_if.sink   in_ch,
  pte_out_if.source out_ch
);
  localparam int PW  = POS_BITS;
  localparam int PW1 = POS_BITS + 1;
  localparam int UW  = $clog2(MAX_PIECES + 1);
  localparam int SW  = $clog2(MAX_PIECES);
  localparam int CW  = $clog2(MAX_PIECES + 3);
  localparam logic [PW-1:0] MASK = '1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOADC  = 9'b000000010,
    S_CHK    = 9'b000000100,
    S_OVF    = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_TAIL   = 9'b000100000,
    S_MRG    = 9'b001000000,
    S_FLUSH  = 9'b010000000,
    S_COMMIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // latched operation
  logic [pte_pkg::FUNC_BITS-1:0] func_r, func_nxt;
  logic [PW-1:0] pos_r, pos_nxt, len_r, len_nxt, ilen_r, ilen_nxt;
  logic [PW-1:0] newlen_r, newlen_nxt, docm_r, docm_nxt, ast_r, ast_nxt;
  logic [PW1-1:0] e_r, e_nxt;

  // table summary
  logic [PW-1:0] doc_r, doc_nxt, addf_r, addf_nxt;
  logic [UW-1:0] used_r, used_nxt;

  // scan state
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [1:0]     ph_r, ph_nxt;
  logic [PW1-1:0] cum_r, cum_nxt, end_r, end_nxt;
  logic [PW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic           cgep_r, cgep_nxt, clt_r, clt_nxt, clte_r, clte_nxt;
  logic           ins_done_r, ins_done_nxt;

  // piece handed to the normalizer
  logic          pc_v_r, pc_v_nxt, pc_src_r, pc_src_nxt;
  logic [PW-1:0] pc_st_r, pc_st_nxt, pc_ln_r, pc_ln_nxt;

  // output word register
  logic                            out_v_r, out_v_nxt;
  logic [pte_pkg::STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic                            out_src_r, out_src_nxt, out_last_r, out_last_nxt;
  logic [PW-1:0] out_st_r, out_st_nxt, out_ln_r, out_ln_nxt, out_doc_r, out_doc_nxt;
  logic [pte_pkg::COUNT_BITS-1:0]  out_cnt_r, out_cnt_nxt;

  // scratch
  logic                            step, acc, slot_ok, adv, err;
  logic                            is_edit, is_read, is_loc, range_ok;
  logic [PW-1:0]                   erlen_c, roff;
  logic                            em, em_src, em_last;
  logic [pte_pkg::STATUS_BITS-1:0] em_status;
  logic [PW-1:0]                   em_st, em_ln;
  pte_pkg::pte_ctl_t               ctl;

  // cell ring
  logic          c_src [MAX_PIECES];
  logic [PW-1:0] c_st  [MAX_PIECES];
  logic [PW-1:0] c_ln  [MAX_PIECES];
  logic          ld_wr, wr_src;
  logic [CW-1:0] wr_idx;
  logic [PW-1:0] wr_st, wr_ln;

  // normalizer
  logic          m_wr_en, m_wr_src;
  logic [CW-1:0] m_wr_idx, m_cnt;
  logic [PW-1:0] m_wr_st, m_wr_ln;

  assign step = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign acc  = in_ch.valid && (state_r == S_IDLE);

  assign is_edit = (func_r == pte_pkg::FN_INS) || (func_r == pte_pkg::FN_ERA) ||
                   (func_r == pte_pkg::FN_REP);
  assign is_read = (func_r == pte_pkg::FN_READ);
  assign is_loc  = (func_r == pte_pkg::FN_LOC);
  assign range_ok = (pos_r <= doc_r) && (len_r <= (doc_r - pos_r));
  assign erlen_c  = (func_r == pte_pkg::FN_INS) ? '0 : len_r;
  assign slot_ok  = (UW'(slot_r) < used_r);

  // load writes its single span straight into rebuild entry zero
  assign ld_wr  = acc && (in_ch.func == pte_pkg::FN_LOAD);
  assign wr_idx = ld_wr ? '0 : m_wr_idx;
  assign wr_src = ld_wr ? 1'b0 : m_wr_src;
  assign wr_st  = ld_wr ? '0 : m_wr_st;
  assign wr_ln  = ld_wr ? in_ch.length : m_wr_ln;

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    ilen_nxt     = ilen_r;
    newlen_nxt   = newlen_r;
    docm_nxt     = docm_r;
    ast_nxt      = ast_r;
    e_nxt        = e_r;
    doc_nxt      = doc_r;
    addf_nxt     = addf_r;
    used_nxt     = used_r;
    slot_nxt     = slot_r;
    ph_nxt       = ph_r;
    cum_nxt      = cum_r;
    end_nxt      = end_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    cgep_nxt     = cgep_r;
    clt_nxt      = clt_r;
    clte_nxt     = clte_r;
    ins_done_nxt = ins_done_r;
    pc_v_nxt     = pc_v_r;
    pc_src_nxt   = pc_src_r;
    pc_st_nxt    = pc_st_r;
    pc_ln_nxt    = pc_ln_r;
    ctl          = '0;
    adv          = 1'b0;
    err          = 1'b0;
    roff         = '0;
    em           = 1'b0;
    em_status    = pte_pkg::ST_OK;
    em_src       = 1'b0;
    em_st        = '0;
    em_ln        = '0;
    em_last      = 1'b1;

    if (acc) begin
      func_nxt  = in_ch.func;
      pos_nxt   = in_ch.position;
      len_nxt   = in_ch.length;
      ilen_nxt  = in_ch.insert_length;
      ast_nxt   = addf_r;
      state_nxt = (in_ch.func == pte_pkg::FN_LOAD) ? S_LOADC : S_CHK;
    end

    if (step) begin
      pc_v_nxt = 1'b0;
      case (state_r)
        S_IDLE: begin
        end
        S_LOADC: begin
          ctl.commit = 1'b1;
          doc_nxt    = len_r;
          addf_nxt   = '0;
          used_nxt   = (len_r != '0) ? UW'(1) : '0;
          em         = 1'b1;
          state_nxt  = S_IDLE;
        end
        S_CHK: begin
          newlen_nxt   = (func_r == pte_pkg::FN_INS) ? len_r :
                         ((func_r == pte_pkg::FN_REP) ? ilen_r : '0);
          docm_nxt     = doc_r - erlen_c;
          e_nxt        = {1'b0, pos_r} + {1'b0, erlen_c};
          slot_nxt     = '0;
          ph_nxt       = 2'd0;
          cum_nxt      = '0;
          ins_done_nxt = 1'b0;
          case (func_r)
            pte_pkg::FN_INS:  err = (pos_r > doc_r);
            pte_pkg::FN_ERA:  err = !range_ok;
            pte_pkg::FN_REP:  err = !range_ok;
            pte_pkg::FN_LOC:  err = (pos_r >= doc_r);
            pte_pkg::FN_READ: err = !range_ok;
            default:          err = 1'b1;
          endcase
          if (err) begin
            em        = 1'b1;
            em_status = pte_pkg::ST_RANGE;
            state_nxt = S_IDLE;
          end else if (is_read && (len_r == '0)) begin
            em        = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = is_edit ? S_OVF : S_SCAN;
          end
        end
        S_OVF: begin
          if ((newlen_r > (MASK - docm_r)) || (newlen_r > (MASK - addf_r))) begin
            em        = 1'b1;
            em_status = pte_pkg::ST_RANGE;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
        S_SCAN: begin
          if (!slot_ok) begin
            ctl.shift = 1'b1;
            adv       = 1'b1;
          end else begin
            case (ph_r)
              2'd0: begin
                // span bounds relative to the operation
                end_nxt  = cum_r + {1'b0, c_ln[0]};
                a_nxt    = pos_r - cum_r[PW-1:0];
                b_nxt    = PW'(e_r - cum_r);
                cgep_nxt = ({1'b0, pos_r} >= cum_r);
                clt_nxt  = ({1'b0, pos_r} > cum_r);
                clte_nxt = (cum_r < e_r);
                ph_nxt   = 2'd1;
              end
              2'd1: begin
                if (is_edit && clt_r) begin
                  // part before the edit point
                  pc_v_nxt   = 1'b1;
                  pc_src_nxt = c_src[0];
                  pc_st_nxt  = c_st[0];
                  pc_ln_nxt  = (end_r <= {1'b0, pos_r}) ? c_ln[0] : a_r;
                end
                if (is_read && (end_r > {1'b0, pos_r}) && clte_r) begin
                  em      = 1'b1;
                  em_src  = c_src[0];
                  em_st   = c_st[0] + (cgep_r ? a_r : '0);
                  em_ln   = PW'(((end_r < e_r) ? end_r : e_r) -
                                (cgep_r ? {1'b0, pos_r} : cum_r));
                  em_last = (end_r >= e_r);
                end
                if (is_loc && cgep_r && ({1'b0, pos_r} < end_r)) begin
                  em     = 1'b1;
                  em_src = c_src[0];
                  em_st  = c_st[0] + a_r;
                  em_ln  = PW'(1);
                end
                ph_nxt = 2'd2;
              end
              2'd2: begin
                // new add span goes in where the edit point falls
                if (is_edit && !ins_done_r && (end_r > {1'b0, pos_r})) begin
                  ins_done_nxt = 1'b1;
                  if (newlen_r != '0) begin
                    pc_v_nxt   = 1'b1;
                    pc_src_nxt = 1'b1;
                    pc_st_nxt  = ast_r;
                    pc_ln_nxt  = newlen_r;
                  end
                end
                ph_nxt = 2'd3;
              end
              default: begin
                // part after the erased range
                if (is_edit && (end_r > e_r)) begin
                  roff       = clte_r ? b_r : '0;
                  pc_v_nxt   = 1'b1;
                  pc_src_nxt = c_src[0];
                  pc_st_nxt  = c_st[0] + roff;
                  pc_ln_nxt  = c_ln[0] - roff;
                end
                cum_nxt   = end_r;
                ctl.shift = 1'b1;
                adv       = 1'b1;
              end
            endcase
          end
          if (adv) begin
            ph_nxt = 2'd0;
            if (slot_r == SW'(MAX_PIECES - 1)) begin
              state_nxt = is_edit ? S_TAIL : S_IDLE;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end
        end
        S_TAIL: begin
          // insert at the document end
          if (!ins_done_r && (newlen_r != '0)) begin
            pc_v_nxt   = 1'b1;
            pc_src_nxt = 1'b1;
            pc_st_nxt  = ast_r;
            pc_ln_nxt  = newlen_r;
          end
          state_nxt = S_MRG;
        end
        S_MRG: begin
          state_nxt = S_FLUSH;
        end
        S_FLUSH: begin
          state_nxt = S_COMMIT;
        end
        S_COMMIT: begin
          em = 1'b1;
          if (m_cnt > CW'(MAX_PIECES)) begin
            em_status = pte_pkg::ST_FULL;
          end else begin
            ctl.commit = 1'b1;
            used_nxt   = UW'(m_cnt);
            doc_nxt    = docm_r + newlen_r;
            addf_nxt   = addf_r + newlen_r;
            if (newlen_r != '0) begin
              em_src = 1'b1;
              em_st  = ast_r;
              em_ln  = newlen_r;
            end
          end
          state_nxt = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end

    ctl.wr_en = ld_wr || m_wr_en;

    out_v_nxt      = out_v_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;
    out_st_nxt     = out_st_r;
    out_ln_nxt     = out_ln_r;
    out_doc_nxt    = out_doc_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    if (em) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = em_status;
      out_src_nxt    = em_src;
      out_st_nxt     = em_st;
      out_ln_nxt     = em_ln;
      out_doc_nxt    = doc_nxt;
      out_cnt_nxt    = pte_pkg::COUNT_BITS'(used_nxt);
      out_last_nxt   = em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      pc_v_r  <= 1'b0;
      used_r  <= '0;
      doc_r   <= '0;
      addf_r  <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      pc_v_r  <= pc_v_nxt;
      used_r  <= used_nxt;
      doc_r   <= doc_nxt;
      addf_r  <= addf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pos_r        <= pos_nxt;
    len_r        <= len_nxt;
    ilen_r       <= ilen_nxt;
    newlen_r     <= newlen_nxt;
    docm_r       <= docm_nxt;
    ast_r        <= ast_nxt;
    e_r          <= e_nxt;
    slot_r       <= slot_nxt;
    ph_r         <= ph_nxt;
    cum_r        <= cum_nxt;
    end_r        <= end_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    cgep_r       <= cgep_nxt;
    clt_r        <= clt_nxt;
    clte_r       <= clte_nxt;
    ins_done_r   <= ins_done_nxt;
    pc_src_r     <= pc_src_nxt;
    pc_st_r      <= pc_st_nxt;
    pc_ln_r      <= pc_ln_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_st_r     <= out_st_nxt;
    out_ln_r     <= out_ln_nxt;
    out_doc_r    <= out_doc_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ring: each cell takes its upper neighbor's span, the top wraps to the head
  for (genvar i = 0; i < MAX_PIECES; i++) begin : g_cell
    pte_cell #(
      .POS_BITS(POS_BITS),
      .CW      (CW),
      .INDEX   (CW'(i))
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .wr_src (wr_src),
      .wr_st  (wr_st),
      .wr_ln  (wr_ln),
      .nb_src (c_src[(i + 1) % MAX_PIECES]),
      .nb_st  (c_st[(i + 1) % MAX_PIECES]),
      .nb_ln  (c_ln[(i + 1) % MAX_PIECES]),
      .old_src(c_src[i]),
      .old_st (c_st[i]),
      .old_ln (c_ln[i])
    );
  end

  pte_merge #(
    .POS_BITS(POS_BITS),
    .CW      (CW)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step),
    .clear (acc),
    .flush (state_r == S_FLUSH),
    .pc_v  (pc_v_r),
    .pc_src(pc_src_r),
    .pc_st (pc_st_r),
    .pc_ln (pc_ln_r),
    .wr_en (m_wr_en),
    .wr_idx(m_wr_idx),
    .wr_src(m_wr_src),
    .wr_st (m_wr_st),
    .wr_ln (m_wr_ln),
    .cnt   (m_cnt)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.span_source = out_src_r;
  assign out_ch.span_start  = out_st_r;
  assign out_ch.span_length = out_ln_r;
  assign out_ch.doc_length  = out_doc_r;
  assign out_ch.span_count  = out_cnt_r;
  assign out_ch.last        = out_last_r;
endmodule
`default_nettype wire

/* design/pte_cell.sv */
`default_nettype none
// One table slot: committed span (rotates with neighbors) plus a rebuild entry.
module pte_cell #(
  parameter int POS_BITS = pte_pkg::DEF_POS_BITS,
  parameter int CW = 6,
  parameter logic [CW-1:0] INDEX = '0
) (
  input  logic                clk,
  input  pte_pkg::pte_ctl_t   ctl,
  input  logic [CW-1:0]       wr_idx,
  input  logic                wr_src,
  input  logic [POS_BITS-1:0] wr_st,
  input  logic [POS_BITS-1:0] wr_ln,
  input  logic                nb_src,
  input  logic [POS_BITS-1:0] nb_st,
  input  logic [POS_BITS-1:0] nb_ln,
  output logic                old_src,
  output logic [POS_BITS-1:0] old_st,
  output logic [POS_BITS-1:0] old_ln
);
  logic                old_src_r, new_src_r;
  logic [POS_BITS-1:0] old_st_r, old_ln_r, new_st_r, new_ln_r;

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      old_src_r <= new_src_r;
      old_st_r  <= new_st_r;
      old_ln_r  <= new_ln_r;
    end else if (ctl.shift) begin
      old_src_r <= nb_src;
      old_st_r  <= nb_st;
      old_ln_r  <= nb_ln;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (wr_idx == INDEX)) begin
      new_src_r <= wr_src;
      new_st_r  <= wr_st;
      new_ln_r  <= wr_ln;
    end
  end

  assign old_src = old_src_r;
  assign old_st  = old_st_r;
  assign old_ln  = old_ln_r;
endmodule
`default_nettype wire

/* design/pte_merge.sv */
`default_nettype none
// Normalizer: drops nothing itself (pieces arrive non-empty), folds contiguous
// same-source pieces into a pending span and writes finished spans in order.
module pte_merge #(
  parameter int POS_BITS = pte_pkg::DEF_POS_BITS,
  parameter int CW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                clear,
  input  logic                flush,
  input  logic                pc_v,
  input  logic                pc_src,
  input  logic [POS_BITS-1:0] pc_st,
  input  logic [POS_BITS-1:0] pc_ln,
  output logic                wr_en,
  output logic [CW-1:0]       wr_idx,
  output logic                wr_src,
  output logic [POS_BITS-1:0] wr_st,
  output logic [POS_BITS-1:0] wr_ln,
  output logic [CW-1:0]       cnt
);
  logic                pv_r, ps_r;
  logic [POS_BITS-1:0] pst_r, pln_r;
  logic [CW-1:0]       cnt_r;
  logic                mrg_ok;

  assign mrg_ok = pv_r && (pc_src == ps_r) &&
                  (({1'b0, pst_r} + {1'b0, pln_r}) == {1'b0, pc_st});

  assign wr_en  = en && !clear && pv_r && ((pc_v && !mrg_ok) || (!pc_v && flush));
  assign wr_idx = cnt_r;
  assign wr_src = ps_r;
  assign wr_st  = pst_r;
  assign wr_ln  = pln_r;
  assign cnt    = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
    end else if (clear) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
    end else if (en) begin
      if (pc_v && !mrg_ok) begin
        pv_r <= 1'b1;
        if (pv_r) cnt_r <= cnt_r + 1'b1;
      end else if (!pc_v && flush && pv_r) begin
        pv_r  <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !clear && pc_v) begin
      if (mrg_ok) begin
        pln_r <= pln_r + pc_ln;
      end else begin
        ps_r  <= pc_src;
        pst_r <= pc_st;
        pln_r <= pc_ln;
      end
    end
  end
endmodule
`default_nettype wire

/* design/pte_checker.sv */
`default_nettype none
`include "piece_table_editor_core_macros.svh"
module pte_checker #(
  parameter int POS_BITS = pte_pkg::DEF_POS_BITS
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [pte_pkg::STATUS_BITS-1:0] out_status,
  input wire logic [POS_BITS-1:0]             out_span_start,
  input wire logic [POS_BITS-1:0]             out_span_length,
  input wire logic                            out_last
);
  // held result word stays put
  `PTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_span_start) && $stable(out_span_length) && $stable(out_last))
  // one word at a time: busy right after taking one
  `PTE_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // error words carry no span and close the operation
  `PTE_ASSERT_IMP(a_err_shape, out_valid && (out_status != pte_pkg::ST_OK), (out_span_start == '0) && (out_span_length == '0) && out_last)
  // only single-word results report an empty span
  `PTE_ASSERT_IMP(a_empty_is_last, out_valid && (out_span_length == '0), out_last)
endmodule

bind piece_table_editor_core pte_checker #(.POS_BITS(POS_BITS)) u_pte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_span_start (out_ch.span_start),
  .out_span_length(out_ch.span_length),
  .out_last       (out_ch.last)
);
`default_nettype wire

/* dv/piece_table_editor_core_tb.sv */
`timescale 1ns / 1ps
module piece_table_editor_core_tb;

  localparam int  PIECES   = pte_pkg::DEF_MAX_PIECES;
  localparam int  SCRATCH  = PIECES + 4;
  localparam longint PMASK = 64'hFF_FFFF;
  localparam int  LIMIT    = 1_000_000;
  localparam int  DRAIN    = 300;     // longer than one full-table edit

  logic clk;
  logic rst_n;

  pte_in_if  in_ch ();
  pte_out_if out_ch ();

  piece_table_editor_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // One expected result word.
  typedef struct {
    logic [pte_pkg::STATUS_BITS-1:0] status;
    logic                            src;
    logic [23:0]                     start;
    logic [23:0]                     len;
    logic [23:0]                     doc;
    logic [pte_pkg::COUNT_BITS-1:0]  cnt;
    logic                            last;
  } span_word_t;

  span_word_t span_words_due[$];

  // Committed table as the block should hold it.
  logic   tbl_src [SCRATCH];
  longint tbl_st  [SCRATCH];
  longint tbl_ln  [SCRATCH];
  int     tbl_n;
  longint doc_size;
  longint add_fill;

  // Working copy an edit is built in before it is committed.
  logic   wk_src [SCRATCH];
  longint wk_st  [SCRATCH];
  longint wk_ln  [SCRATCH];
  int     wk_n;

  int in_idle_pct;
  int out_stall_pct;
  int mismatches;
  int cycles;

  function automatic void push_word(logic [1:0] st, logic s, longint sst, longint sln,
                                    logic lst);
    span_word_t w;
    w.status = st;
    w.src    = s;
    w.start  = sst[23:0];
    w.len    = sln[23:0];
    w.doc    = doc_size[23:0];
    w.cnt    = tbl_n[pte_pkg::COUNT_BITS-1:0];
    w.last   = lst;
    span_words_due = {span_words_due, w};
  endfunction

  function automatic void locate_pos(longint pos, output int idx, output longint off);
    longint cum;
    cum = 0;
    for (int i = 0; i < wk_n; i++) begin
      if (pos < cum + wk_ln[i]) begin
        idx = i;
        off = pos - cum;
        return;
      end
      cum += wk_ln[i];
    end
    idx = wk_n;
    off = 0;
  endfunction

  function automatic void wk_put(int idx, logic s, longint st, longint ln);
    if (wk_n >= SCRATCH || idx > wk_n) return;
    for (int i = wk_n; i > idx; i--) begin
      wk_src[i] = wk_src[i-1];
      wk_st[i]  = wk_st[i-1];
      wk_ln[i]  = wk_ln[i-1];
    end
    wk_src[idx] = s;
    wk_st[idx]  = st;
    wk_ln[idx]  = ln;
    wk_n++;
  endfunction

  function automatic void wk_drop(int idx);
    if (idx >= wk_n) return;
    for (int i = idx; i + 1 < wk_n; i++) begin
      wk_src[i] = wk_src[i+1];
      wk_st[i]  = wk_st[i+1];
      wk_ln[i]  = wk_ln[i+1];
    end
    wk_n--;
  endfunction

  // Drop empty spans, merge neighbors contiguous in the same store.
  function automatic void wk_normalize();
    int w;
    w = 0;
    for (int i = 0; i < wk_n; i++) begin
      if (wk_ln[i] == 0) continue;
      if (w > 0 && wk_src[w-1] == wk_src[i] && wk_st[w-1] + wk_ln[w-1] == wk_st[i]) begin
        wk_ln[w-1] += wk_ln[i];
        continue;
      end
      wk_src[w] = wk_src[i];
      wk_st[w]  = wk_st[i];
      wk_ln[w]  = wk_ln[i];
      w++;
    end
    wk_n = w;
  endfunction

  function automatic void wk_insert(longint pos, longint ast, longint len);
    int idx;
    longint off, st, ln;
    logic s;
    locate_pos(pos, idx, off);
    if (idx >= wk_n) begin
      wk_put(wk_n, 1'b1, ast, len);
    end else if (off == 0) begin
      wk_put(idx, 1'b1, ast, len);
    end else begin
      s  = wk_src[idx];
      st = wk_st[idx];
      ln = wk_ln[idx];
      wk_ln[idx] = off;
      wk_put(idx + 1, 1'b1, ast, len);
      wk_put(idx + 2, s, st + off, ln - off);
    end
    wk_normalize();
  endfunction

  function automatic void wk_erase(longint pos, longint len);
    int idx;
    longint off, rem, avail, take;
    rem = len;
    locate_pos(pos, idx, off);
    while (rem > 0 && idx < wk_n) begin
      avail = wk_ln[idx] - off;
      take  = rem < avail ? rem : avail;
      if (off == 0 && take == wk_ln[idx]) begin
        wk_drop(idx);
      end else if (off == 0) begin
        wk_st[idx] += take;
        wk_ln[idx] -= take;
        idx++;
      end else if (off + take == wk_ln[idx]) begin
        wk_ln[idx] = off;
        idx++;
      end else begin
        wk_ln[idx] = off;
        wk_put(idx + 1, wk_src[idx], wk_st[idx] + off + take, avail - take);
        idx += 2;
      end
      rem -= take;
      off = 0;
    end
    wk_normalize();
  endfunction

  function automatic void wk_from_table();
    wk_n = tbl_n;
    for (int i = 0; i < tbl_n; i++) begin
      wk_src[i] = tbl_src[i];
      wk_st[i]  = tbl_st[i];
      wk_ln[i]  = tbl_ln[i];
    end
  endfunction

  // Applies one accepted word to the table and queues the words it returns.
  function automatic void edit_and_report(logic [2:0] fn, longint pos, longint len,
                                          longint ilen);
    logic   range_ok;
    longint newlen, erlen, ast, rest, off, rem, take;
    int     idx, k;
    range_ok = pos <= doc_size && len <= doc_size - pos;
    case (fn)
      pte_pkg::FN_LOAD: begin
        tbl_n    = 0;
        add_fill = 0;
        doc_size = len;
        if (len > 0) begin
          tbl_src[0] = 1'b0;
          tbl_st[0]  = 0;
          tbl_ln[0]  = len;
          tbl_n      = 1;
        end
        push_word(pte_pkg::ST_OK, 0, 0, 0, 1);
      end
      pte_pkg::FN_INS, pte_pkg::FN_ERA, pte_pkg::FN_REP: begin
        newlen = fn == pte_pkg::FN_INS ? len : (fn == pte_pkg::FN_REP ? ilen : 0);
        erlen  = fn == pte_pkg::FN_INS ? 0 : len;
        ast    = add_fill;
        if (fn == pte_pkg::FN_INS ? pos > doc_size : !range_ok) begin
          push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
          return;
        end
        rest = doc_size - erlen;
        if (newlen > PMASK - rest || newlen > PMASK - add_fill) begin
          push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
          return;
        end
        wk_from_table();
        if (erlen > 0) wk_erase(pos, erlen);
        if (newlen > 0) wk_insert(pos, ast, newlen);
        if (wk_n > PIECES) begin
          // table would overflow: nothing changes
          push_word(pte_pkg::ST_FULL, 0, 0, 0, 1);
          return;
        end
        tbl_n = wk_n;
        for (int i = 0; i < wk_n; i++) begin
          tbl_src[i] = wk_src[i];
          tbl_st[i]  = wk_st[i];
          tbl_ln[i]  = wk_ln[i];
        end
        doc_size = rest + newlen;
        add_fill = add_fill + newlen;
        if (newlen > 0) push_word(pte_pkg::ST_OK, 1, ast, newlen, 1);
        else push_word(pte_pkg::ST_OK, 0, 0, 0, 1);
      end
      pte_pkg::FN_LOC: begin
        if (pos >= doc_size) begin
          push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
          return;
        end
        wk_from_table();
        locate_pos(pos, idx, off);
        if (idx >= wk_n) push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
        else push_word(pte_pkg::ST_OK, wk_src[idx], wk_st[idx] + off, 1, 1);
      end
      pte_pkg::FN_READ: begin
        if (!range_ok) begin
          push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
          return;
        end
        if (len == 0) begin
          push_word(pte_pkg::ST_OK, 0, 0, 0, 1);
          return;
        end
        wk_from_table();
        locate_pos(pos, idx, off);
        rem = len;
        k   = 0;
        while (rem > 0 && idx < wk_n && k < PIECES) begin
          take = rem < wk_ln[idx] - off ? rem : wk_ln[idx] - off;
          push_word(pte_pkg::ST_OK, wk_src[idx], wk_st[idx] + off, take, 0);
          k++;
          rem -= take;
          idx++;
          off = 0;
        end
        if (k == 0) push_word(pte_pkg::ST_OK, 0, 0, 0, 1);
        else span_words_due[$].last = 1'b1;
      end
      default: push_word(pte_pkg::ST_RANGE, 0, 0, 0, 1);
    endcase
  endfunction

  // Sends one word; valid stays high into the next word unless the sender idles.
  task automatic send_op(logic [2:0] fn, logic [23:0] pos, logic [23:0] len,
                         logic [23:0] ilen = 24'd0);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= fn;
    in_ch.position      <= pos;
    in_ch.length        <= len;
    in_ch.insert_length <= ilen;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    edit_and_report(fn, longint'(pos), longint'(len), longint'(ilen));
  endtask

  // Waits until the block has returned everything and gone quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (span_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Random offset into the current document, 0..doc_size.
  function automatic logic [23:0] any_pos();
    return 24'($urandom_range(int'(doc_size)));
  endfunction

  // A well-formed edit or query against the current document.
  task automatic send_sane_op();
    int pick;
    longint p, room;
    pick = $urandom_range(99);
    p    = any_pos();
    room = doc_size - p;
    if (pick < 35) send_op(pte_pkg::FN_INS, 24'(p), 24'($urandom_range(1, 20)));
    else if (pick < 50)
      send_op(pte_pkg::FN_ERA, 24'(p), 24'($urandom_range(int'(room > 12 ? 12 : room))));
    else if (pick < 62)
      send_op(pte_pkg::FN_REP, 24'(p), 24'($urandom_range(int'(room > 8 ? 8 : room))),
              24'($urandom_range(8)));
    else if (pick < 77)
      send_op(pte_pkg::FN_LOC,
              doc_size == 0 ? 24'd0 : 24'($urandom_range(int'(doc_size) - 1)), 0);
    else if (pick < 95) send_op(pte_pkg::FN_READ, 24'(p), 24'($urandom_range(int'(room))));
    else send_op(pte_pkg::FN_LOAD, 0, 24'($urandom_range(20, 400)));
  endtask

  // Random junk over every field, most of it out of range.
  task automatic send_noise_op();
    logic [2:0] fn;
    fn = 3'($urandom_range(7));
    if (fn == pte_pkg::FN_LOAD) fn = pte_pkg::FN_READ;
    send_op(fn, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic test_directed();
    send_op(pte_pkg::FN_LOC, 0, 0);                      // locate on an empty document
    send_op(pte_pkg::FN_READ, 0, 0);                     // empty read
    send_op(pte_pkg::FN_INS, 1, 1);                      // insert past end
    send_op(pte_pkg::FN_LOAD, 0, 0);                     // load nothing
    send_op(pte_pkg::FN_LOAD, 0, 100);
    send_op(pte_pkg::FN_INS, 0, 5);                      // insert at front
    send_op(pte_pkg::FN_INS, 105, 3);                    // append
    send_op(pte_pkg::FN_INS, 50, 4);                     // split a span
    send_op(pte_pkg::FN_INS, 54, 2);                     // grows the add span in place
    send_op(pte_pkg::FN_INS, 20, 0);                     // empty insert
    send_op(pte_pkg::FN_ERA, 10, 0);                     // empty erase
    send_op(pte_pkg::FN_ERA, 30, 10);                    // erase inside one span
    send_op(pte_pkg::FN_ERA, 0, 7);                      // erase across spans
    send_op(pte_pkg::FN_REP, 40, 6, 9);
    send_op(pte_pkg::FN_REP, 3, 2, 0);                   // replace with nothing
    send_op(pte_pkg::FN_LOC, 45, 0);
    send_op(pte_pkg::FN_LOC, 24'hFFFFFF, 0);
    send_op(pte_pkg::FN_READ, 0, 24'(doc_size));         // whole document
    send_op(pte_pkg::FN_READ, 5, 24'hFFFFFF);            // bad range
    send_op(pte_pkg::FN_ERA, 24'hFFFFFF, 1);
    send_op(3'd6, 1, 1, 1);                              // unknown func codes
    send_op(3'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_op(pte_pkg::FN_LOAD, 0, 24'hFFFFFF);            // largest document
    send_op(pte_pkg::FN_INS, 24'hFFFFFF, 1);             // document size overflow
    send_op(pte_pkg::FN_REP, 0, 24'hFFFFFF, 24'hFFFFFF); // replace all, largest text
  endtask

  // Splits original text until the table cannot take another piece.
  task automatic test_table_full();
    send_op(pte_pkg::FN_LOAD, 0, 2000);
    for (int i = 0; i < 22; i++)
      send_op(pte_pkg::FN_INS, any_pos(), 24'($urandom_range(1, 3)));
    send_op(pte_pkg::FN_READ, 0, 24'(doc_size));         // whole document, one word per span
    send_op(pte_pkg::FN_ERA, 24'($urandom_range(int'(doc_size) - 1)), 1);
  endtask

  // Add store overflow: nearly fill it, then ask for more than is left.
  task automatic test_add_overflow();
    send_op(pte_pkg::FN_LOAD, 0, 10);
    send_op(pte_pkg::FN_INS, 5, 24'hFFFFF0);
    send_op(pte_pkg::FN_REP, 0, 20, 24'hF);              // exactly fills the add store
    send_op(pte_pkg::FN_INS, 0, 1);                      // one too many
    send_op(pte_pkg::FN_ERA, 0, 24'(doc_size));
    send_op(pte_pkg::FN_LOAD, 0, 64);
  endtask

  task automatic test_random_edits(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_noise_op();
      else send_sane_op();
    end
  endtask

  // Result check: every accepted word against the oldest one due.
  always @(posedge clk) begin
    span_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (span_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: status %0d start %0h len %0h",
                                       out_ch.status, out_ch.span_start, out_ch.span_length);
      end else begin
        w = span_words_due.pop_front();
        if (out_ch.status !== w.status || out_ch.span_source !== w.src ||
            out_ch.span_start !== w.start || out_ch.span_length !== w.len ||
            out_ch.doc_length !== w.doc || out_ch.span_count !== w.cnt ||
            out_ch.last !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st %0d src %0d start %0h len %0h doc %0h cnt %0d last %0d",
                     w.status, w.src, w.start, w.len, w.doc, w.cnt, w.last,
                     " / got st %0d src %0d start %0h len %0h doc %0h cnt %0d last %0d",
                     out_ch.status, out_ch.span_source, out_ch.span_start,
                     out_ch.span_length, out_ch.doc_length, out_ch.span_count, out_ch.last);
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL piece_table_editor_core");
      $finish;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.func          = pte_pkg::FN_LOAD;
    in_ch.position      = '0;
    in_ch.length        = '0;
    in_ch.insert_length = '0;
    out_ch.ready        = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    mismatches    = 0;
    cycles        = 0;
    tbl_n         = 0;
    doc_size      = 0;
    add_fill      = 0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_add_overflow();

    // idling phases: none, sender idle, receiver stalls, both
    test_random_edits(50);
    in_idle_pct = 70;
    test_random_edits(45);
    in_idle_pct   = 0;
    out_stall_pct = 70;
    test_table_full();
    test_random_edits(45);
    in_idle_pct   = 14;
    out_stall_pct = 14;
    test_random_edits(50);
    settle();

    if (mismatches == 0 && span_words_due.size() == 0) begin
      $display("PASS piece_table_editor_core");
    end else begin
      $display("FAIL piece_table_editor_core");
    end
    $finish;
  end

endmodule
